>>> hw/rtl/fab_pkg.sv
// Shared types, constants and pixel helpers for the framebuffer alpha blit block.
package fab_pkg;

    // Field widths of the request and response channels.
    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int PIXEL_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ALPHA_W  = 8;
    localparam int ORIGIN_W = 10;

    // Screen coordinates after the origin is added: 10-bit origin plus 12-bit offset.
    localparam int COORD_W = 13;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ALPHA = 2'd2;

    // Request types.
    localparam logic REQ_BLIT    = 1'b0;
    localparam logic REQ_CAPTURE = 1'b1;

    localparam logic [PIXEL_W-1:0] OPAQUE_BLACK = 32'hff00_0000;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL   = 8'hff;
    localparam logic [ALPHA_W-1:0] ALPHA_NONE   = 8'h00;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_CLIPPED  = 2'd1,
        STAT_REJECTED = 2'd2,
        STAT_FILLED   = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_READ,
        S_MODIFY
    } t_state;

    // Exchange the red and blue bytes of a 32-bit pixel.
    function automatic logic [PIXEL_W-1:0] swap_rb(input logic [PIXEL_W-1:0] p);
        return {p[31:24], p[7:0], p[15:8], p[23:16]};
    endfunction

endpackage

>>> hw/rtl/fab_if.sv
// Request and response channel interfaces of the framebuffer alpha blit block.
interface fab_req_if;
    import fab_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [PIXEL_W-1:0] src_pixel;

    modport source (output valid, output req_type, output col, output row,
                    output src_pixel, input ready);
    modport sink   (input valid, input req_type, input col, input row,
                    input src_pixel, output ready);
endinterface

interface fab_rsp_if;
    import fab_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIXEL_W-1:0]  read_pixel;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output read_pixel, output status, input ready);
    modport sink   (input valid, input read_pixel, input status, output ready);
endinterface

>>> hw/rtl/framebuffer_alpha_blit.sv
// Framebuffer with per-pixel alpha blit and capture over one frame memory.
//
//  Channel   Direction  Handshake        Contents
//  i_req     in         valid / ready    req_type, col, row, src_pixel
//  o_rsp     out        valid / ready    read_pixel, status
//  i_cfg_*   in         write enable     origin_x, origin_y, window_alpha
//
// Each request passes through the steps accept, address multiply, memory read,
// then modify and write back; the frame memory's read is registered. After reset
// a clearing pass writes opaque black to all SCREEN_W * SCREEN_H words, one per
// cycle, and no request is taken until it ends. A response waiting in the output
// register does not block the next request; only the modify step waits for that
// register to free up.
module framebuffer_alpha_blit #(
    parameter int SCREEN_W = 600,
    parameter int SCREEN_H = 800
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fab_req_if.sink                        i_req,
    fab_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [fab_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fab_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fab_pkg::*;

    localparam int DEPTH  = SCREEN_W * SCREEN_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * COORD_W;

    // Configuration registers.
    logic [ORIGIN_W-1:0] r_origin_x;
    logic [ORIGIN_W-1:0] r_origin_y;
    logic [ALPHA_W-1:0]  r_window_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_window_alpha <= ALPHA_FULL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data[ORIGIN_W-1:0];
                CFG_WINDOW_ALPHA: r_window_alpha <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and clearing counter.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                clr_last;
    logic                req_accept;
    logic                out_free;

    assign clr_last   = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign req_accept = i_req.valid && i_req.ready;

    // Request registers captured at accept.
    logic                r_req_type;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic [PIXEL_W-1:0]  r_src;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [2*ALPHA_W-1:0] alpha_prod;

    // Scaled source alpha: (window_alpha * source alpha) >> 8.
    assign alpha_prod = (2*ALPHA_W)'(r_window_alpha) * (2*ALPHA_W)'(i_req.src_pixel[31:24]);

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_req_type <= i_req.req_type;
            r_x        <= COORD_W'(r_origin_x) + COORD_W'(i_req.col);
            r_y        <= COORD_W'(r_origin_y) + COORD_W'(i_req.row);
            r_src      <= i_req.src_pixel;
            r_alpha    <= alpha_prod[2*ALPHA_W-1:ALPHA_W];
        end
    end

    // Address stage: linear index and screen checks.
    logic [PROD_W-1:0]   n_lin;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_on_screen;
    logic                r_origin_ok;

    assign n_lin = PROD_W'(r_y) * PROD_W'(SCREEN_W) + PROD_W'(r_x);

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_addr      <= n_lin[ADDR_W-1:0];
            r_on_screen <= (r_x < COORD_W'(SCREEN_W)) && (r_y < COORD_W'(SCREEN_H));
            r_origin_ok <= (COORD_W'(r_origin_x) <= COORD_W'(SCREEN_W))
                        && (COORD_W'(r_origin_y) <= COORD_W'(SCREEN_H));
        end
    end

    // Frame memory. Accesses never overlap: an item writes in its last step
    // and the next item reads only after passing the idle and address states.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [PIXEL_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [PIXEL_W-1:0]  ram_rdata;

    fab_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Blend datapath on the stored pixel.
    logic [PIXEL_W-1:0]  blend_pixel;

    fab_blend u_blend (
        .i_src   (r_src),
        .i_dst   (ram_rdata),
        .i_alpha (r_alpha),
        .o_pixel (blend_pixel)
    );

    // Modify decision: what to write and what to report.
    logic                src_opaque;
    logic                src_clear;
    logic                mod_write;
    logic [PIXEL_W-1:0]  mod_wdata;
    logic [PIXEL_W-1:0]  mod_pixel;
    t_status             mod_status;

    assign src_opaque = (r_window_alpha == ALPHA_FULL) && (r_src[31:24] == ALPHA_FULL);
    assign src_clear  = (r_window_alpha == ALPHA_NONE) || (r_src[31:24] == ALPHA_NONE);

    always_comb begin
        mod_write  = 1'b0;
        mod_wdata  = blend_pixel;
        mod_pixel  = '0;
        mod_status = STAT_DONE;
        if (r_req_type == REQ_BLIT) begin
            priority if (!r_on_screen) begin
                mod_status = STAT_CLIPPED;
            end else if (src_opaque) begin
                mod_write = 1'b1;
                mod_wdata = swap_rb(r_src);
            end else if (!src_clear) begin
                mod_write = 1'b1;
            end else begin
                // A transparent source or window leaves the stored pixel as it is.
                mod_write = 1'b0;
            end
        end else begin
            priority if (!r_origin_ok) begin
                mod_status = STAT_REJECTED;
            end else if (!r_on_screen) begin
                mod_pixel  = OPAQUE_BLACK;
                mod_status = STAT_FILLED;
            end else begin
                mod_pixel  = swap_rb(ram_rdata);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (clr_last)   n_state = S_IDLE;
            S_IDLE:   if (req_accept) n_state = S_ADDR;
            S_ADDR:   n_state = S_READ;
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: if (out_free)   n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Output logic of the sequencer.
    logic out_load;

    always_comb begin
        i_req.ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = mod_wdata;
        ram_re      = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = OPAQUE_BLACK;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_ADDR: ;
            S_READ: begin
                ram_re = 1'b1;
            end
            S_MODIFY: begin
                ram_we   = mod_write && out_free;
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Output register; it frees up as soon as the current response is taken.
    logic                r_out_valid;
    logic [PIXEL_W-1:0]  r_out_pixel;
    t_status             r_out_status;

    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pixel  <= mod_pixel;
            r_out_status <= mod_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_pixel = r_out_pixel;
    assign o_rsp.status     = r_out_status;
endmodule

>>> hw/rtl/fab_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module fab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/fab_blend.sv
// Per-channel blend of a swapped source pixel over a stored pixel, opaque result.
module fab_blend (
    input  logic [fab_pkg::PIXEL_W-1:0] i_src,
    input  logic [fab_pkg::PIXEL_W-1:0] i_dst,
    input  logic [fab_pkg::ALPHA_W-1:0] i_alpha,
    output logic [fab_pkg::PIXEL_W-1:0] o_pixel
);
    import fab_pkg::*;

    logic [PIXEL_W-1:0] src_sw;
    logic [ALPHA_W-1:0] inv_alpha;

    // The source is swapped first so that each channel sits where the store keeps it.
    assign src_sw    = swap_rb(i_src);
    assign inv_alpha = ALPHA_FULL - i_alpha;

    // Three color lanes: (s * a + d * (255 - a)) >> 8, never above 16 bits.
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [15:0] prod_s;
        logic [15:0] prod_d;
        logic [15:0] sum;

        assign prod_s = 16'(src_sw[ch*8 +: 8]) * 16'(i_alpha);
        assign prod_d = 16'(i_dst[ch*8 +: 8]) * 16'(inv_alpha);
        assign sum    = prod_s + prod_d;
        assign o_pixel[ch*8 +: 8] = sum[15:8];
    end

    assign o_pixel[31:24] = OPAQUE_BLACK[31:24];
endmodule

>>> hw/rtl/fab_checker.sv
// Port-level checks on the framebuffer alpha blit block, bound to the top level.
module fab_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [fab_pkg::PIXEL_W-1:0]    i_rsp_pixel,
    input logic [fab_pkg::STATUS_W-1:0]   i_rsp_status
);
    import fab_pkg::*;

    logic req_accept;
    assign req_accept = i_req_valid && i_req_ready;

    // A waiting response holds until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_pixel)
                                        && $stable(i_rsp_status))
        else $error("response changed while stalled");

    // One request at a time: the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> !i_req_ready)
        else $error("request taken while previous one in progress");

    // A response never appears the cycle right after its request was taken.
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(req_accept))
        else $error("response produced too early");

    // Clipped and rejected requests carry no pixel; filled ones carry black.
    a_status_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            ((i_rsp_status != STAT_CLIPPED && i_rsp_status != STAT_REJECTED)
             || i_rsp_pixel == '0)
            && (i_rsp_status != STAT_FILLED || i_rsp_pixel == OPAQUE_BLACK))
        else $error("response pixel does not match its status");
endmodule

bind framebuffer_alpha_blit fab_checker u_fab_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_pixel  (o_rsp.read_pixel),
    .i_rsp_status (o_rsp.status)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the framebuffer alpha blit block, with a mirrored frame store.
module testbench;
    import fab_pkg::*;

    localparam int SCREEN_W    = 600;
    localparam int SCREEN_H    = 800;
    localparam int FB_WORDS    = SCREEN_W * SCREEN_H;
    localparam int ORIGIN_MAX  = (1 << ORIGIN_W) - 1;
    localparam int COL_MAX     = (1 << COL_W) - 1;
    localparam int ROW_MAX     = (1 << ROW_W) - 1;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 123;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 2_000_000;

    // Mirror of the frame store and window registers; keeps the responses each request should produce.
    class blit_scoreboard;
        typedef struct packed {
            logic [PIXEL_W-1:0] pixel;
            t_status            status;
        } t_rsp;

        bit [PIXEL_W-1:0] shadow_fb [FB_WORDS];
        t_rsp             pending_rsp [$];
        int               origin_x;
        int               origin_y;
        bit [ALPHA_W-1:0] win_alpha;
        int               errors;

        function new();
            for (int i = 0; i < FB_WORDS; i++) begin
                shadow_fb[i] = OPAQUE_BLACK;
            end
            origin_x  = 0;
            origin_y  = 0;
            win_alpha = ALPHA_FULL;
            errors    = 0;
        endfunction

        function void set_window(input int ox, input int oy, input int wa);
            origin_x  = ox & ORIGIN_MAX;
            origin_y  = oy & ORIGIN_MAX;
            win_alpha = wa[ALPHA_W-1:0];
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        static function bit [PIXEL_W-1:0] exchange_rb(input bit [PIXEL_W-1:0] p);
            return {p[31:24], p[7:0], p[15:8], p[23:16]};
        endfunction

        static function bit [7:0] mix_channel(input int s, input int d, input int a);
            int sum;
            sum = (s * a) + (d * (255 - a));
            return 8'(sum >> 8);
        endfunction

        // Apply one accepted request to the mirror and queue the response it must produce.
        function void apply_request(input logic kind, input logic [COL_W-1:0] col,
                                    input logic [ROW_W-1:0] row,
                                    input logic [PIXEL_W-1:0] src);
            int               x;
            int               y;
            int               idx;
            int               a;
            bit [7:0]         src_a;
            bit [PIXEL_W-1:0] dst;
            bit [7:0]         r;
            bit [7:0]         g;
            bit [7:0]         b;
            t_rsp             exp_rsp;

            x = origin_x + int'(col);
            y = origin_y + int'(row);
            idx = y * SCREEN_W + x;
            exp_rsp.pixel  = '0;
            exp_rsp.status = STAT_DONE;
            if (kind == REQ_BLIT) begin
                if (x >= SCREEN_W || y >= SCREEN_H) begin
                    exp_rsp.status = STAT_CLIPPED;
                end else begin
                    src_a = src[31:24];
                    if (win_alpha == ALPHA_FULL && src_a == ALPHA_FULL) begin
                        shadow_fb[idx] = exchange_rb(src);
                    end else if (win_alpha != ALPHA_NONE && src_a != ALPHA_NONE) begin
                        dst = shadow_fb[idx];
                        a = (int'(win_alpha) * int'(src_a)) >> 8;
                        r = mix_channel(src[7:0], dst[23:16], a);
                        g = mix_channel(src[15:8], dst[15:8], a);
                        b = mix_channel(src[23:16], dst[7:0], a);
                        shadow_fb[idx] = OPAQUE_BLACK | {8'h00, r, g, b};
                    end
                end
            end else if (origin_x > SCREEN_W || origin_y > SCREEN_H) begin
                exp_rsp.status = STAT_REJECTED;
            end else if (x >= SCREEN_W || y >= SCREEN_H) begin
                exp_rsp.pixel  = OPAQUE_BLACK;
                exp_rsp.status = STAT_FILLED;
            end else begin
                exp_rsp.pixel = exchange_rb(shadow_fb[idx]);
            end
            pending_rsp.push_back(exp_rsp);
        endfunction

        // Compare one accepted response with the oldest queued one.
        function void check_response(input logic [PIXEL_W-1:0] pix,
                                     input logic [STATUS_W-1:0] st);
            t_rsp exp_rsp;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with no request outstanding: pixel %h status %0d",
                         $time, pix, st);
                errors++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (pix !== exp_rsp.pixel) begin
                $display("%0t: read_pixel mismatch: expected %h actual %h",
                         $time, exp_rsp.pixel, pix);
                errors++;
            end
            if (st !== exp_rsp.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_rsp.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    cycle_count = 0;
    int                    requests_sent;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    blit_scoreboard        sb;

    fab_req_if req_ch ();
    fab_rsp_if rsp_ch ();

    framebuffer_alpha_blit #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, sized for the clearing pass plus every request at its slowest.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Response side: check each accepted response and stall ready at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                sb.check_response(rsp_ch.read_pixel, rsp_ch.status);
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Write all three window registers, one per clock.
    task automatic write_window(input int ox, input int oy, input int wa);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ORIGIN_X;
        cfg_data <= CFG_DATA_W'(ox);
        @(posedge i_clk);
        cfg_idx  <= CFG_ORIGIN_Y;
        cfg_data <= CFG_DATA_W'(oy);
        @(posedge i_clk);
        cfg_idx  <= CFG_WINDOW_ALPHA;
        cfg_data <= CFG_DATA_W'(wa & 8'hff);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_window(ox, oy, wa);
    endtask

    // Hold requests off until every response is back, then let the pipeline settle.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Present one request after a random gap and wait for it to be taken.
    task automatic send_request(input logic kind, input logic [COL_W-1:0] col,
                                input logic [ROW_W-1:0] row, input logic [PIXEL_W-1:0] src);
        if (requests_sent < 417) begin
            send_idle_pct = 12;
            recv_idle_pct = 80;
        end else if (requests_sent < 834) begin
            send_idle_pct = 80;
            recv_idle_pct = 12;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.col       <= col;
        req_ch.row       <= row;
        req_ch.src_pixel <= src;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.apply_request(kind, col, row, src);
        requests_sent++;
    endtask

    // Offset that lands on screen when the origin allows, mostly near both edges of the region so pixels get hit again.
    function automatic int pick_offset(input int origin, input int size, input int max_off);
        int last;
        int span;
        if (origin >= size) begin
            return $urandom_range(0, max_off);
        end
        last = size - 1 - origin;
        span = (last < 3) ? last : 3;
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(0, span);
            2:       return last - $urandom_range(0, span);
            default: return $urandom_range(0, last);
        endcase
    endfunction

    // Source pixel with an alpha biased toward the opaque, transparent and edge cases.
    function automatic logic [PIXEL_W-1:0] pick_source();
        logic [7:0] a;
        case ($urandom_range(0, 5))
            0:       a = ALPHA_NONE;
            1, 2:    a = ALPHA_FULL;
            3:       a = 8'($urandom_range(1, 254));
            4:       a = $urandom_range(0, 1) ? 8'd1 : 8'd254;
            default: a = 8'($urandom);
        endcase
        return {a, 24'($urandom)};
    endfunction

    // Window setting of each random phase, extremes included.
    task automatic pick_window(input int p, output int ox, output int oy, output int wa);
        case (p)
            0: begin ox = 0; oy = 0; wa = ALPHA_FULL; end
            1: begin ox = 0; oy = 0; wa = $urandom_range(1, 254); end
            2: begin ox = SCREEN_W - 1; oy = SCREEN_H - 1; wa = ALPHA_FULL; end
            3: begin
                ox = $urandom_range(0, SCREEN_W);
                oy = $urandom_range(0, SCREEN_H);
                wa = ALPHA_FULL;
            end
            4: begin
                ox = $urandom_range(0, SCREEN_W);
                oy = $urandom_range(0, SCREEN_H);
                wa = ALPHA_NONE;
            end
            5: begin
                ox = $urandom_range(SCREEN_W + 1, ORIGIN_MAX);
                oy = $urandom_range(0, ORIGIN_MAX);
                wa = $urandom_range(0, 255);
            end
            6: begin ox = SCREEN_W / 2; oy = SCREEN_H / 2; wa = 1; end
            7: begin
                ox = $urandom_range(0, SCREEN_W);
                oy = $urandom_range(SCREEN_H + 1, ORIGIN_MAX);
                wa = $urandom_range(0, 255);
            end
            8: begin ox = 0; oy = 0; wa = 254; end
            default: begin
                ox = $urandom_range(0, ORIGIN_MAX);
                oy = $urandom_range(0, ORIGIN_MAX);
                wa = $urandom_range(0, 255);
            end
        endcase
    endtask

    // Stimulus: reset, directed requests, then random phases under several window settings.
    initial begin
        int ox;
        int oy;
        int wa;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;

        sb = new();
        requests_sent    = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_ORIGIN_X;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_BLIT;
        req_ch.col       <= '0;
        req_ch.row       <= '0;
        req_ch.src_pixel <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: opaque writes at both corners, clipping, transparent and blended pixels.
        send_request(REQ_BLIT, 0, 0, 32'hff11_2233);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);
        send_request(REQ_BLIT, COL_W'(SCREEN_W - 1), ROW_W'(SCREEN_H - 1), 32'hffff_ffff);
        send_request(REQ_CAPTURE, COL_W'(SCREEN_W - 1), ROW_W'(SCREEN_H - 1), 32'h0);
        send_request(REQ_BLIT, COL_W'(SCREEN_W), 0, 32'hff12_3456);
        send_request(REQ_BLIT, 0, ROW_W'(SCREEN_H), 32'hff12_3456);
        send_request(REQ_BLIT, COL_W'(COL_MAX), ROW_W'(ROW_MAX), 32'hffff_ffff);
        send_request(REQ_CAPTURE, COL_W'(SCREEN_W), 0, 32'hffff_ffff);
        send_request(REQ_CAPTURE, COL_W'(COL_MAX), ROW_W'(ROW_MAX), 32'h0);
        send_request(REQ_BLIT, 0, 0, 32'h00ab_cdef);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);
        send_request(REQ_BLIT, 0, 0, 32'h80ff_0000);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);

        // Invisible window leaves the store alone; a half window blends.
        drain_responses();
        write_window(0, 0, ALPHA_NONE);
        send_request(REQ_BLIT, 1, 0, 32'hff00_ff00);
        send_request(REQ_CAPTURE, 1, 0, 32'h0);
        drain_responses();
        write_window(0, 0, 128);
        send_request(REQ_BLIT, 1, 0, 32'hff40_80c0);
        send_request(REQ_CAPTURE, 1, 0, 32'h0);
        send_request(REQ_BLIT, 1, 0, 32'h01ff_ffff);
        send_request(REQ_CAPTURE, 1, 0, 32'h0);

        // Origins just past the edge reject a capture; origins on the edge only fill black.
        drain_responses();
        write_window(SCREEN_W + 1, 0, ALPHA_FULL);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);
        send_request(REQ_BLIT, 0, 0, 32'hff00_0001);
        drain_responses();
        write_window(SCREEN_W, SCREEN_H, ALPHA_FULL);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);
        send_request(REQ_BLIT, 0, 0, 32'hff00_0001);
        drain_responses();
        write_window(0, SCREEN_H + 1, ALPHA_FULL);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);
        drain_responses();
        write_window(ORIGIN_MAX, ORIGIN_MAX, ALPHA_FULL);
        send_request(REQ_CAPTURE, 0, 0, 32'h0);

        // Random phases: mostly on-screen requests that revisit the same pixels, some noise.
        for (int p = 0; p < PHASES; p++) begin
            drain_responses();
            pick_window(p, ox, oy, wa);
            write_window(ox, oy, wa);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) begin
                    drain_responses();
                end
                if ($urandom_range(0, 9) < 7) begin
                    col = COL_W'(pick_offset(ox, SCREEN_W, COL_MAX));
                    row = ROW_W'(pick_offset(oy, SCREEN_H, ROW_MAX));
                end else begin
                    col = COL_W'($urandom_range(0, COL_MAX));
                    row = ROW_W'($urandom_range(0, ROW_MAX));
                end
                send_request($urandom_range(0, 1) ? REQ_CAPTURE : REQ_BLIT, col, row,
                             pick_source());
            end
        end

        drain_responses();
        repeat (2 * SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> framebuffer_alpha_blit.f
hw/rtl/fab_pkg.sv
hw/rtl/fab_if.sv
hw/rtl/fab_ram.sv
hw/rtl/fab_blend.sv
hw/rtl/framebuffer_alpha_blit.sv
hw/rtl/fab_checker.sv
tb/sv/testbench.sv
